// ===== hw/rtl/gdil_pkg.sv =====
// Shared constants and register codes of the 3x3 gray dilation unit.
package gdil_pkg;

   localparam int COLS_REG_BITS  = 11;
   localparam int ROWS_REG_BITS  = 13;
   localparam int PASS_REG_BITS  = 3;
   localparam int CSR_DATA_BITS  = 13;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [COLS_REG_BITS-1:0] COLS_RESET = 11'd640;
   localparam logic [ROWS_REG_BITS-1:0] ROWS_RESET = 13'd480;
   localparam logic [PASS_REG_BITS-1:0] PASS_RESET = 3'd1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_COLS = 2'd0,
      CSR_FRAME_ROWS = 2'd1,
      CSR_PASS_COUNT = 2'd2
   } csr_index_type;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

endpackage

// ===== hw/rtl/gdil_stage.sv =====
// One dilation pass: two line stores, vertical/horizontal max window, output tracking.
module gdil_stage import gdil_pkg::*; #(
   parameter int MAX_COLS   = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step_en,
   input  logic                               have,
   input  logic [PIXEL_BITS-1:0]              pix,
   input  logic [$clog2(MAX_COLS+1)-1:0]      nc,
   input  logic [ROWS_REG_BITS-1:0]           nr,
   output logic                               emit,
   output logic [PIXEL_BITS-1:0]              res,
   output logic                               last
);

   localparam int CW  = $clog2(MAX_COLS);
   localparam int LW  = $clog2(MAX_COLS + 2);
   localparam int RW  = ROWS_REG_BITS;

   function automatic logic [PIXEL_BITS-1:0] pmax(input logic [PIXEL_BITS-1:0] a,
                                                   input logic [PIXEL_BITS-1:0] b);
      pmax = (a > b) ? a : b;
   endfunction

   // control state
   logic [CW-1:0]         wcol_ff, wcol_in;
   logic [RW-1:0]         wrow_ff, wrow_in;
   logic [CW-1:0]         out_col_ff, out_col_in;
   logic [RW-1:0]         out_row_ff, out_row_in;
   logic [LW-1:0]         lag_ff, lag_in;
   logic                  behind_ff, behind_in;
   logic [PIXEL_BITS-1:0] win0_ff, win0_in;
   logic [PIXEL_BITS-1:0] win1_ff, win1_in;

   // line stores, prefetched column c+1 and column 0 copies
   logic [PIXEL_BITS-1:0] mem0 [MAX_COLS];
   logic [PIXEL_BITS-1:0] mem1 [MAX_COLS];
   logic [PIXEL_BITS-1:0] rd0_ff, rd1_ff;
   logic [PIXEL_BITS-1:0] col0_p0_ff, col0_p1_ff;
   logic [CW-1:0]         rd_addr;
   logic                  we0, we1;

   logic                  use_in, origin, col_more, has_below, has_below2;
   logic [CW:0]           c_inc, wc_inc;
   logic [RW:0]           r_inc, r_inc2, wr_inc;
   logic [PIXEL_BITS-1:0] cur_rd, oth_rd, cur_c0, oth_c0;
   logic [PIXEL_BITS-1:0] right_v, below_v, cen, left, right;
   logic [LW-1:0]         lag_mid;

   assign c_inc      = {1'b0, out_col_ff} + (CW+1)'(1);
   assign wc_inc     = {1'b0, wcol_ff} + (CW+1)'(1);
   assign r_inc      = {1'b0, out_row_ff} + (RW+1)'(1);
   assign r_inc2     = {1'b0, out_row_ff} + (RW+1)'(2);
   assign wr_inc     = {1'b0, wrow_ff} + (RW+1)'(1);

   assign emit       = behind_ff || (have && (lag_ff > LW'(nc)));
   assign use_in     = have && !behind_ff;
   assign origin     = (out_row_ff == '0) && (out_col_ff == '0);
   assign col_more   = c_inc < (CW+1)'(nc);
   assign has_below  = r_inc < {1'b0, nr};
   assign has_below2 = r_inc2 < {1'b0, nr};

   // rows r-1 and r+1 share a store, so only the two parities matter
   assign cur_rd = out_row_ff[0] ? rd1_ff : rd0_ff;
   assign oth_rd = out_row_ff[0] ? rd0_ff : rd1_ff;
   assign cur_c0 = out_row_ff[0] ? col0_p1_ff : col0_p0_ff;
   assign oth_c0 = out_row_ff[0] ? col0_p0_ff : col0_p1_ff;

   always_comb begin
      right_v = cur_rd;
      if (out_row_ff != '0) begin
         right_v = pmax(right_v, oth_rd);
      end
      if (has_below) begin
         right_v = pmax(right_v, use_in ? pix : oth_rd);
      end
      // vertical max at column 0 of the next row
      below_v = pmax(oth_c0, cur_c0);
      if (has_below2) begin
         below_v = pmax(below_v, use_in ? pix : cur_c0);
      end
   end

   assign cen   = origin ? pmax(col0_p0_ff, col0_p1_ff) : win1_ff;
   assign left  = (out_col_ff != '0) ? win0_ff : '0;
   assign right = col_more ? right_v : '0;
   assign res   = pmax(pmax(cen, left), right);
   assign last  = emit && !col_more && !has_below;

   always_comb begin
      wcol_in    = wcol_ff;
      wrow_in    = wrow_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      behind_in  = behind_ff;
      win0_in    = win0_ff;
      win1_in    = win1_ff;
      lag_mid    = lag_ff;
      lag_in     = lag_ff;
      if (step_en && emit) begin
         if (col_more) begin
            win0_in    = cen;
            win1_in    = right_v;
            out_col_in = c_inc[CW-1:0];
         end else begin
            out_col_in = '0;
            win0_in    = '0;
            if (has_below) begin
               win1_in    = below_v;
               out_row_in = r_inc[RW-1:0];
            end else begin
               out_row_in = '0;
               behind_in  = 1'b0;
            end
         end
         if (lag_ff != '0) begin
            lag_mid = lag_ff - LW'(1);
         end
      end
      lag_in = lag_mid;
      if (step_en && have) begin
         lag_in = lag_mid + LW'(1);
         if (wc_inc >= (CW+1)'(nc)) begin
            wcol_in = '0;
            if (wr_inc >= {1'b0, nr}) begin
               wrow_in   = '0;
               behind_in = 1'b1;
            end else begin
               wrow_in = wr_inc[RW-1:0];
            end
         end else begin
            wcol_in = wc_inc[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wcol_ff    <= '0;
         wrow_ff    <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         lag_ff     <= '0;
         behind_ff  <= 1'b0;
         win0_ff    <= '0;
         win1_ff    <= '0;
      end else begin
         wcol_ff    <= wcol_in;
         wrow_ff    <= wrow_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         lag_ff     <= lag_in;
         behind_ff  <= behind_in;
         win0_ff    <= win0_in;
         win1_ff    <= win1_in;
      end
   end

   // prefetch the column right of the next output; forward a same-cycle write
   assign rd_addr = out_col_in + CW'(1);
   assign we0     = step_en && have && !wrow_ff[0];
   assign we1     = step_en && have && wrow_ff[0];

   always_ff @(posedge clock) begin
      if (we0) begin
         mem0[wcol_ff] <= pix;
      end
      rd0_ff <= (we0 && (wcol_ff == rd_addr)) ? pix : mem0[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we1) begin
         mem1[wcol_ff] <= pix;
      end
      rd1_ff <= (we1 && (wcol_ff == rd_addr)) ? pix : mem1[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we0 && (wcol_ff == '0)) begin
         col0_p0_ff <= pix;
      end
      if (we1 && (wcol_ff == '0)) begin
         col0_p1_ff <= pix;
      end
   end

endmodule

// ===== hw/rtl/gray_dilation_3x3_unit.sv =====
// Top level of the cascaded 3x3 gray dilation unit.
// Takes one item per clock while no result is held, and gives one result per
// clock at most. Each item passes one register per pass stage (MAX_PASSES of
// them, the first being the input register; unused ones just forward) and
// then the result register. A held result stalls the whole cascade; a
// one-entry skid in front keeps req_tready registered. A pixel comes out
// once the pixel one row and one column further has arrived in every active
// pass; after the last pixel of a frame, send drain items (req_tuser = 1) to
// push the remaining pixels out, or start the next frame. Frame geometry and
// pass count must be changed only while idle; the block does not enforce it.
// The line stores need no clearing after reset.
module gray_dilation_3x3_unit import gdil_pkg::*; #(
   parameter int MAX_COLS   = 1024,
   parameter int MAX_PASSES = 4,
   parameter int PIXEL_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((PIXEL_BITS+7)/8)*8-1:0]       req_tdata,   // pixel_in
   input  logic                                  req_tuser,   // kind
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((PIXEL_BITS+7)/8)*8-1:0]       rsp_tdata,   // pixel_out
   output logic                                  rsp_tlast,
   input  logic                                  csr_we,
   input  logic [CSR_INDEX_BITS-1:0]             csr_index,
   input  logic [CSR_DATA_BITS-1:0]              csr_wdata
);

   localparam int DATA_BITS = ((PIXEL_BITS + 7) / 8) * 8;
   localparam int NCW       = $clog2(MAX_COLS + 1);

   // configuration
   logic [COLS_REG_BITS-1:0] cols_ff;
   logic [ROWS_REG_BITS-1:0] rows_ff;
   logic [PASS_REG_BITS-1:0] passes_ff;
   logic [NCW-1:0]           nc;
   logic [ROWS_REG_BITS-1:0] nr;
   logic                     active [MAX_PASSES];

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff   <= COLS_RESET;
         rows_ff   <= ROWS_RESET;
         passes_ff <= PASS_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_COLS: cols_ff   <= csr_wdata[COLS_REG_BITS-1:0];
            CSR_FRAME_ROWS: rows_ff   <= csr_wdata[ROWS_REG_BITS-1:0];
            CSR_PASS_COUNT: passes_ff <= csr_wdata[PASS_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (cols_ff < COLS_REG_BITS'(2)) begin
         nc = NCW'(2);
      end else if (int'(cols_ff) > MAX_COLS) begin
         nc = NCW'(MAX_COLS);
      end else begin
         nc = NCW'(cols_ff);
      end
   end

   assign nr = (rows_ff < ROWS_REG_BITS'(2)) ? ROWS_REG_BITS'(2) : rows_ff;

   // pass count of zero still runs the first stage
   always_comb begin
      for (int s = 0; s < MAX_PASSES; s++) begin
         active[s] = (s == 0) || (s < int'(passes_ff));
      end
   end

   // skid entry and pipeline advance
   logic                  skid_valid_ff;
   logic                  skid_kind_ff;
   logic [PIXEL_BITS-1:0] skid_pix_ff;
   logic                  advance;
   logic                  src_valid;
   logic                  src_kind;
   logic [PIXEL_BITS-1:0] src_pix;

   logic                  rsp_valid_ff;
   logic [PIXEL_BITS-1:0] rsp_pix_ff;
   logic                  rsp_last_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !skid_valid_ff;
   assign src_valid  = skid_valid_ff || req_tvalid;
   assign src_kind   = skid_valid_ff ? skid_kind_ff : req_tuser;
   assign src_pix    = skid_valid_ff ? skid_pix_ff : req_tdata[PIXEL_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (advance) begin
         skid_valid_ff <= 1'b0;
      end else if (req_tvalid && !skid_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_kind_ff <= req_tuser;
         skid_pix_ff  <= req_tdata[PIXEL_BITS-1:0];
      end
   end

   // stage input slots; slot 0 is the input register
   logic                  slot_valid_ff [MAX_PASSES];
   logic                  slot_have_ff  [MAX_PASSES];
   logic [PIXEL_BITS-1:0] slot_pix_ff   [MAX_PASSES];
   logic                  slot_last_ff  [MAX_PASSES];

   logic                  st_emit [MAX_PASSES];
   logic [PIXEL_BITS-1:0] st_res  [MAX_PASSES];
   logic                  st_last [MAX_PASSES];
   logic                  nxt_have [MAX_PASSES];
   logic [PIXEL_BITS-1:0] nxt_pix  [MAX_PASSES];
   logic                  nxt_last [MAX_PASSES];

   for (genvar g = 0; g < MAX_PASSES; g++) begin : g_pass
      gdil_stage #(
         .MAX_COLS   (MAX_COLS),
         .PIXEL_BITS (PIXEL_BITS)
      ) u_stage (
         .clock   (clock),
         .reset   (reset),
         .step_en (advance && slot_valid_ff[g] && active[g]),
         .have    (slot_have_ff[g]),
         .pix     (slot_pix_ff[g]),
         .nc      (nc),
         .nr      (nr),
         .emit    (st_emit[g]),
         .res     (st_res[g]),
         .last    (st_last[g])
      );

      // bypass passes beyond the pass count
      assign nxt_have[g] = active[g] ? st_emit[g] : slot_have_ff[g];
      assign nxt_pix[g]  = active[g] ? st_res[g]  : slot_pix_ff[g];
      assign nxt_last[g] = active[g] ? st_last[g] : slot_last_ff[g];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < MAX_PASSES; s++) begin
            slot_valid_ff[s] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         slot_valid_ff[0] <= src_valid;
         for (int s = 1; s < MAX_PASSES; s++) begin
            slot_valid_ff[s] <= slot_valid_ff[s-1];
         end
         // drop items that leave no result
         rsp_valid_ff <= slot_valid_ff[MAX_PASSES-1] && nxt_have[MAX_PASSES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         slot_have_ff[0] <= (src_kind == KIND_PIXEL);
         slot_pix_ff[0]  <= src_pix;
         slot_last_ff[0] <= 1'b0;
         for (int s = 1; s < MAX_PASSES; s++) begin
            slot_have_ff[s] <= nxt_have[s-1];
            slot_pix_ff[s]  <= nxt_pix[s-1];
            slot_last_ff[s] <= nxt_last[s-1];
         end
         rsp_pix_ff  <= nxt_pix[MAX_PASSES-1];
         rsp_last_ff <= nxt_last[MAX_PASSES-1];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_BITS'(rsp_pix_ff);
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the cascaded 3x3 gray dilation unit.
`timescale 1ns / 100ps

module tb import gdil_pkg::*;;

   localparam int MAX_COLS    = 1024;
   localparam int MAX_PASSES  = 4;
   localparam int DRAIN_SLACK = 12;

   typedef struct packed {
      logic [7:0] pixel;
      logic       frame_end;
   } dilated_px_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata  = '0;   // pixel_in
   logic                      req_tuser  = KIND_PIXEL;   // kind
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [7:0]                rsp_tdata;   // pixel_out
   logic                      rsp_tlast;
   logic                      csr_we     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index  = CSR_FRAME_COLS;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;

   // predictor state: register copies and per-pass line stores and counters
   bit [COLS_REG_BITS-1:0] cfg_cols   = COLS_RESET;
   bit [ROWS_REG_BITS-1:0] cfg_rows   = ROWS_RESET;
   bit [PASS_REG_BITS-1:0] cfg_passes = PASS_RESET;
   bit [7:0]    line_mem [MAX_PASSES][2][MAX_COLS];
   bit [7:0]    win_left [MAX_PASSES];
   bit [7:0]    win_mid  [MAX_PASSES];
   int unsigned wr_col   [MAX_PASSES];
   int unsigned wr_row   [MAX_PASSES];
   int unsigned rd_col   [MAX_PASSES];
   int unsigned rd_row   [MAX_PASSES];
   int unsigned backlog  [MAX_PASSES];
   bit          flushing [MAX_PASSES];

   dilated_px_type dil_expect_q[$];
   int unsigned err_count    = 0;
   int unsigned rsp_count    = 0;
   int unsigned pixels_sent  = 0;
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;

   gray_dilation_3x3_unit #(
      .MAX_COLS  (MAX_COLS),
      .MAX_PASSES(MAX_PASSES),
      .PIXEL_BITS(8)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int unsigned cols_used();
      if (cfg_cols < 2) return 2;
      if (cfg_cols > MAX_COLS) return MAX_COLS;
      return cfg_cols;
   endfunction

   function automatic int unsigned rows_used();
      return (cfg_rows < 2) ? 2 : cfg_rows;
   endfunction

   function automatic int unsigned passes_used();
      if (cfg_passes < 1) return 1;
      if (cfg_passes > MAX_PASSES) return MAX_PASSES;
      return cfg_passes;
   endfunction

   // vertical max of rows r-1, r, r+1 at column c; the row below may be the arriving pixel
   function automatic bit [7:0] col_max(int s, int unsigned r, int unsigned c, bit take_new,
                                        bit [7:0] pix, int unsigned nrows);
      bit [7:0] v, u, below;
      v = line_mem[s][r % 2][c];
      // rows r-1 and r+1 share one store
      u = line_mem[s][(r + 1) % 2][c];
      if (r > 0 && u > v) v = u;
      if (r + 1 < nrows) begin
         below = take_new ? pix : u;
         if (below > v) v = below;
      end
      return v;
   endfunction

   function automatic bit stage_advance(int s, bit have, bit [7:0] pix,
                                        output bit [7:0] res, output bit last);
      int unsigned nc, nr, r, c;
      bit          was_flushing, emit, take_new;
      bit [7:0]    mid, left, right;
      nc = cols_used();
      nr = rows_used();
      was_flushing = flushing[s];
      emit = was_flushing || (have && backlog[s] >= nc + 1);
      take_new = have && !was_flushing;
      res = '0;
      last = 1'b0;
      if (emit) begin
         r = rd_row[s];
         c = rd_col[s];
         right = '0;
         if (r == 0 && c == 0) win_mid[s] = col_max(s, 0, 0, 1'b0, 8'h00, nr);
         mid = win_mid[s];
         left = (c > 0) ? win_left[s] : 8'h00;
         if (c + 1 < nc) begin
            right = col_max(s, r, c + 1, take_new, pix, nr);
            win_left[s] = mid;
            win_mid[s] = right;
            rd_col[s] = c + 1;
         end else begin
            rd_col[s] = 0;
            win_left[s] = '0;
            if (r + 1 < nr) begin
               win_mid[s] = col_max(s, r + 1, 0, take_new, pix, nr);
               rd_row[s] = r + 1;
            end else begin
               rd_row[s] = 0;
               flushing[s] = 1'b0;
               last = 1'b1;
            end
         end
         res = mid;
         if (left > res) res = left;
         if (right > res) res = right;
         if (backlog[s] > 0) backlog[s]--;
      end
      if (have) begin
         line_mem[s][wr_row[s] % 2][wr_col[s]] = pix;
         backlog[s]++;
         if (wr_col[s] + 1 >= nc) begin
            wr_col[s] = 0;
            if (wr_row[s] + 1 >= nr) begin
               wr_row[s] = 0;
               flushing[s] = 1'b1;
            end else begin
               wr_row[s]++;
            end
         end else begin
            wr_col[s]++;
         end
      end
      return emit;
   endfunction

   function automatic bit dilate_item(logic kind, bit [7:0] pix, output dilated_px_type px);
      bit          have, lst;
      bit [7:0]    val, res;
      int unsigned n;
      have = (kind == KIND_PIXEL);
      val = pix;
      lst = 1'b0;
      n = passes_used();
      for (int s = 0; s < n; s++) begin
         have = stage_advance(s, have, val, res, lst);
         val = res;
      end
      px.pixel = val;
      px.frame_end = lst;
      return have;
   endfunction

   function automatic bit backlog_pending();
      for (int s = 0; s < passes_used(); s++)
         if (backlog[s] != 0 || flushing[s]) return 1'b1;
      return 1'b0;
   endfunction

   function automatic int unsigned pick_gap(int unsigned pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(15) == 0) return $urandom_range(40, 10);
      return $urandom_range(3, 1);
   endfunction

   function automatic int unsigned pick_idle();
      case ($urandom_range(3))
         0: return 0;
         1: return 15;
         2: return 50;
         default: return 85;
      endcase
   endfunction

   function automatic bit [7:0] pick_pixel();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         2, 3: return 8'($urandom_range(255));
         default: return 8'($urandom_range(31));
      endcase
   endfunction

   task automatic send_item(input logic kind, input bit [7:0] pix);
      dilated_px_type px;
      int unsigned gap;
      gap = pick_gap(req_idle_pct);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= pix;
      do begin
         @(posedge clock);
      end while (!req_tready);
      if (dilate_item(kind, pix, px)) dil_expect_q.push_back(px);
      if (kind == KIND_PIXEL) pixels_sent++;
   endtask

   // hold the sender until every expected result has arrived and the pipe is empty
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (dil_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic program_regs(input int unsigned cols, input int unsigned rows,
                               input int unsigned passes);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= CSR_FRAME_COLS;
      csr_wdata <= CSR_DATA_BITS'(cols);
      @(posedge clock);
      csr_index <= CSR_FRAME_ROWS;
      csr_wdata <= CSR_DATA_BITS'(rows);
      @(posedge clock);
      csr_index <= CSR_PASS_COUNT;
      csr_wdata <= CSR_DATA_BITS'(passes);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_cols = COLS_REG_BITS'(cols);
      cfg_rows = ROWS_REG_BITS'(rows);
      cfg_passes = PASS_REG_BITS'(passes);
   endtask

   task automatic send_frame(input int unsigned noise_pct);
      int unsigned total;
      total = cols_used() * rows_used();
      for (int unsigned i = 0; i < total; i++) begin
         if ($urandom_range(99) < noise_pct) send_item(KIND_DRAIN, 8'($urandom));
         if ($urandom_range(199) == 0) wait_drained();
         send_item(KIND_PIXEL, pick_pixel());
      end
   endtask

   task automatic flush_frame();
      while (backlog_pending()) send_item(KIND_DRAIN, 8'($urandom));
   endtask

   task automatic test_directed();
      bit [7:0] ramp [9];
      bit [7:0] spot [9];
      ramp = '{8'hFF, 8'h00, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h00, 8'h7F, 8'h00};
      spot = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00};
      req_idle_pct = 30;
      rsp_idle_pct = 30;
      program_regs(3, 3, 1);
      // drain with nothing complete: no result
      send_item(KIND_DRAIN, 8'hFF);
      foreach (ramp[i]) begin
         send_item(KIND_PIXEL, ramp[i]);
         if (i == 1) send_item(KIND_DRAIN, 8'h5A);
      end
      // next frame right away pushes out the pending pixels of the first
      foreach (spot[i]) send_item(KIND_PIXEL, spot[i]);
      flush_frame();
   endtask

   task automatic test_range_clamps();
      req_idle_pct = 50;
      rsp_idle_pct = 50;
      program_regs(0, 0, 0);
      send_frame(0);
      flush_frame();
      program_regs(1, 1, 7);
      send_frame(0);
      send_frame(10);
      flush_frame();
      program_regs(5, 3, 5);
      send_frame(0);
      flush_frame();
   endtask

   task automatic test_wide_frame();
      req_idle_pct = 0;
      rsp_idle_pct = 10;
      program_regs(128, 2, 2);
      send_frame(0);
      flush_frame();
   endtask

   task automatic test_tall_frame();
      req_idle_pct = 10;
      rsp_idle_pct = 0;
      program_regs(2, 150, 2);
      send_frame(0);
      flush_frame();
   endtask

   task automatic test_random_frames();
      int unsigned first, wcols, wrows, wpass;
      first = pixels_sent;
      while (pixels_sent - first < 250) begin
         req_idle_pct = pick_idle();
         rsp_idle_pct = pick_idle();
         wcols = ($urandom_range(7) == 0) ? $urandom_range(40, 2) : $urandom_range(12, 2);
         if ($urandom_range(15) == 0) wcols = $urandom_range(1);
         wrows = ($urandom_range(15) == 0) ? $urandom_range(1) : $urandom_range(8, 2);
         wpass = ($urandom_range(7) == 0) ? $urandom_range(7) : $urandom_range(4, 1);
         program_regs(wcols, wrows, wpass);
         repeat ($urandom_range(3, 1)) send_frame($urandom_range(1) ? 10 : 0);
         flush_frame();
      end
   endtask

   always begin : rsp_backpressure
      int unsigned stall;
      @(posedge clock);
      stall = pick_gap(rsp_idle_pct);
      if (stall != 0) begin
         rsp_tready <= 1'b0;
         repeat (stall) @(posedge clock);
      end
      rsp_tready <= 1'b1;
   end

   always @(posedge clock) begin : check_results
      dilated_px_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (dil_expect_q.size() == 0) begin
            err_count++;
            if (err_count <= 10)
               $display("unexpected result %0d: pixel %0d last %0b",
                        rsp_count, rsp_tdata, rsp_tlast);
         end else begin
            want = dil_expect_q.pop_front();
            if (rsp_tdata !== want.pixel || rsp_tlast !== want.frame_end) begin
               err_count++;
               if (err_count <= 10)
                  $display("result %0d: expected pixel %0d last %0b, got pixel %0d last %0b",
                           rsp_count, want.pixel, want.frame_end, rsp_tdata, rsp_tlast);
            end
         end
         rsp_count++;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_range_clamps();
      test_wide_frame();
      test_tall_frame();
      test_random_frames();
      wait_drained();
      if (err_count == 0 && dil_expect_q.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/gdil_pkg.sv
hw/rtl/gdil_stage.sv
hw/rtl/gray_dilation_3x3_unit.sv
dv/tb.sv
